[rtl/crpt_pkg.sv]
//------------------------------------------------------------------------------
// crpt_pkg: shared types and constants of the capture ring pointer tracker
// Field widths, mode and result codes, the bundles that pass between modules,
// and the restoring remainder step used by both modulo units.
//------------------------------------------------------------------------------
`default_nettype none

package crpt_pkg;

	localparam int ADDR_W         = 32;
	localparam int IDX_W          = 17;
	localparam int SIZE_W         = 18;
	localparam int FRAMES_W       = 16;
	localparam int RING_BYTES_MAX = 131072;

	// The address offset is reduced four dividend bits per pipeline stage.
	localparam int STEP_BITS  = 4;
	localparam int DIV_STAGES = ADDR_W / STEP_BITS;

	// Bit counter of the iterative index reduction.
	localparam int CNT_W = $clog2(IDX_W + 1);

	localparam logic [SIZE_W-1:0] RING_MAX_W = SIZE_W'(RING_BYTES_MAX);

	typedef enum logic [0:0] {
		REG_BUFFER_BASE = 1'b0,
		REG_RING_SIZE   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_PROGRESS = 2'd0,
		MODE_READ     = 2'd1,
		MODE_STOP     = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_PROGRESS = 2'd0,
		KIND_SEGMENT  = 2'd1,
		KIND_CLEARED  = 2'd2,
		KIND_IGNORED  = 2'd3
	} kind_t;

	// Side information that travels with an item through the offset pipeline.
	typedef struct packed {
		mode_t               mode;
		logic                addr_zero;
		logic [FRAMES_W-1:0] frames;
	} item_tag_t;

	// Ring pointers as seen by the update logic (indices already below the size).
	typedef struct packed {
		logic [IDX_W-1:0]  wr;
		logic [IDX_W-1:0]  rd;
		logic [SIZE_W-1:0] bw;
	} ring_state_t;

	typedef struct packed {
		kind_t               kind;
		logic [IDX_W-1:0]    new_bytes;
		logic                overflow;
		logic [IDX_W-1:0]    seg_offset;
		logic [SIZE_W-1:0]   seg_bytes;
		logic [FRAMES_W-1:0] total_frames;
		logic                last;
	} result_t;

	// One restoring step: shift in a dividend bit, subtract the size if it fits.
	// With rem below a nonzero size the result stays below the size as well.
	function automatic logic [IDX_W-1:0] mod_step(input logic [IDX_W-1:0] rem,
			input logic b, input logic [SIZE_W-1:0] s);
		logic [SIZE_W-1:0] t;
		t = {rem, b};
		if (t >= s) begin
			t = t - s;
		end
		return t[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

[rtl/capture_ring_pointer_tracker.sv]
//------------------------------------------------------------------------------
// capture_ring_pointer_tracker: capture ring buffer pointer and occupancy tracker
// One item per cycle unless output stalls or a reduction runs; a wrapping read gives two results.
// Results leave through an output register behind the 8-stage offset remainder pipeline.
// Reset clears pointers, config and valid bits; items stall while a size write's reduction runs.
//------------------------------------------------------------------------------
`default_nettype none

module capture_ring_pointer_tracker import crpt_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,

	// Configuration write port.
	input  wire logic                cfg_write_en,
	input  wire logic [0:0]          cfg_index,
	input  wire logic [ADDR_W-1:0]   cfg_data,

	// Input item channel.
	input  wire logic                item_valid,
	output logic                     item_stall,
	input  wire logic [1:0]          mode,
	input  wire logic [ADDR_W-1:0]   hw_address,
	input  wire logic [FRAMES_W-1:0] read_frames,

	// Result item channel.
	output logic                     result_valid,
	input  wire logic                result_stall,
	output logic [1:0]               kind,
	output logic [IDX_W-1:0]         new_bytes,
	output logic                     overflow,
	output logic [IDX_W-1:0]         seg_offset,
	output logic [SIZE_W-1:0]        seg_bytes,
	output logic [FRAMES_W-1:0]      total_frames,
	output logic                     last
);

	// Configuration. Only the effective ring size, clamped to the largest ring,
	// is kept, since the raw size register is never used otherwise.
	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] s_q;
	logic [SIZE_W-1:0] size_clamped;
	logic              size_start;

	// Pointer state. The raw indices hold what was last written; the reduced
	// copies are the raw indices modulo the current size, refreshed by the
	// reduction pass after every nonzero size write. An item writes an index only
	// when it sets that index; an index it leaves alone keeps its raw value,
	// so that a later size change reduces the value last written.
	logic [IDX_W-1:0]  wr_raw_q;
	logic [IDX_W-1:0]  rd_raw_q;
	logic [IDX_W-1:0]  wr_q;
	logic [IDX_W-1:0]  rd_q;
	logic [SIZE_W-1:0] bw_q;

	// Offset pipeline.
	logic              pipe_in_ready;
	logic              pipe_in_valid;
	item_tag_t         pipe_in_tag;
	logic              pipe_out_valid;
	logic              pipe_out_ready;
	logic [IDX_W-1:0]  pipe_out_rem;
	item_tag_t         pipe_out_tag;

	// Reduction pass.
	logic              wr_busy;
	logic              wr_done;
	logic [IDX_W-1:0]  wr_red;
	logic              rd_busy;
	logic              rd_done;
	logic [IDX_W-1:0]  rd_red;
	logic              red_busy;

	// Update logic and output side.
	ring_state_t       cur_state;
	ring_state_t       nxt_state;
	logic              upd;
	logic              two;
	result_t           res0;
	result_t           res1;
	logic              commit;
	logic              out_free;
	logic              wr_set;
	logic              rd_set;

	result_t           res_q;
	result_t           pend_res_q;
	logic              result_valid_q;
	logic              pend_q;

	//--------------------------------------------------------------------------
	// Configuration writes. A nonzero size starts the reduction pass; with a
	// zero size every progress and read item is ignored, so there is nothing
	// to reduce.
	//--------------------------------------------------------------------------
	assign size_clamped = (cfg_data[SIZE_W-1:0] > RING_MAX_W) ? RING_MAX_W
		: cfg_data[SIZE_W-1:0];
	assign size_start = cfg_write_en && (cfg_reg_t'(cfg_index) == REG_RING_SIZE)
		&& (size_clamped != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			s_q    <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BUFFER_BASE: base_q <= cfg_data;
				REG_RING_SIZE:   s_q    <= size_clamped;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Input side. The offset of the reported address from the ring base is
	// taken modulo 2^32 here and reduced modulo the size in the pipeline. The
	// pipeline carries the mode and frame count along so that items reach the
	// update logic in order. No item is taken during the reduction pass.
	//--------------------------------------------------------------------------
	assign pipe_in_tag.mode      = mode_t'(mode);
	assign pipe_in_tag.addr_zero = (hw_address == '0);
	assign pipe_in_tag.frames    = read_frames;
	assign pipe_in_valid         = item_valid && !red_busy;
	assign item_stall            = !pipe_in_ready || red_busy;

	crpt_mod_pipe u_mod_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pipe_in_valid),
		.in_ready  (pipe_in_ready),
		.in_diff   (hw_address - base_q),
		.in_tag    (pipe_in_tag),
		.s         (s_q),
		.out_valid (pipe_out_valid),
		.out_ready (pipe_out_ready),
		.out_rem   (pipe_out_rem),
		.out_tag   (pipe_out_tag)
	);

	//--------------------------------------------------------------------------
	// Reduction pass: both indices in parallel, one bit per cycle from the raw
	// copies, which are loaded at the size write.
	//--------------------------------------------------------------------------
	crpt_idx_reduce u_wr_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (size_start),
		.raw    (wr_raw_q),
		.s      (s_q),
		.busy   (wr_busy),
		.done   (wr_done),
		.rem    (wr_red)
	);

	crpt_idx_reduce u_rd_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (size_start),
		.raw    (rd_raw_q),
		.s      (s_q),
		.busy   (rd_busy),
		.done   (rd_done),
		.rem    (rd_red)
	);

	assign red_busy = wr_busy || rd_busy;

	//--------------------------------------------------------------------------
	// Pointer update. An item leaves the pipeline when the output register is
	// free and no second segment is still waiting for it.
	//--------------------------------------------------------------------------
	assign cur_state.wr = wr_q;
	assign cur_state.rd = rd_q;
	assign cur_state.bw = bw_q;

	crpt_step_logic u_step (
		.tag  (pipe_out_tag),
		.offs (pipe_out_rem),
		.s    (s_q),
		.cur  (cur_state),
		.nxt  (nxt_state),
		.upd  (upd),
		.two  (two),
		.res0 (res0),
		.res1 (res1)
	);

	assign out_free       = !result_valid_q || !result_stall;
	assign pipe_out_ready = out_free && !pend_q;
	assign commit         = pipe_out_valid && pipe_out_ready;

	// A progress report or a stop sets the write index. A read, a stop or an
	// overflow trim sets the read index.
	assign wr_set = upd && (pipe_out_tag.mode == MODE_PROGRESS
		|| pipe_out_tag.mode == MODE_STOP);
	assign rd_set = upd && (pipe_out_tag.mode != MODE_PROGRESS || res0.overflow);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_raw_q <= '0;
			rd_raw_q <= '0;
			wr_q     <= '0;
			rd_q     <= '0;
			bw_q     <= '0;
		end else begin
			if (commit && wr_set) begin
				wr_raw_q <= nxt_state.wr;
			end
			if (commit && rd_set) begin
				rd_raw_q <= nxt_state.rd;
			end
			if (commit && upd) begin
				bw_q <= nxt_state.bw;
			end
			// The end of the reduction pass wins over an item update.
			if (wr_done) begin
				wr_q <= wr_red;
			end else if (commit && wr_set) begin
				wr_q <= nxt_state.wr;
			end
			if (rd_done) begin
				rd_q <= rd_red;
			end else if (commit && rd_set) begin
				rd_q <= nxt_state.rd;
			end
		end
	end

	//--------------------------------------------------------------------------
	// Output register with a one-entry hold for the second segment of a read
	// that wraps. The second segment follows the first in the next free cycle.
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			pend_q         <= 1'b0;
		end else if (commit) begin
			result_valid_q <= 1'b1;
			pend_q         <= two;
		end else if (pend_q && out_free) begin
			result_valid_q <= 1'b1;
			pend_q         <= 1'b0;
		end else if (result_valid_q && !result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q      <= res0;
			pend_res_q <= res1;
		end else if (pend_q && out_free) begin
			res_q <= pend_res_q;
		end
	end

	assign result_valid = result_valid_q;
	assign kind         = res_q.kind;
	assign new_bytes    = res_q.new_bytes;
	assign overflow     = res_q.overflow;
	assign seg_offset   = res_q.seg_offset;
	assign seg_bytes    = res_q.seg_bytes;
	assign total_frames = res_q.total_frames;
	assign last         = res_q.last;

	// A waiting second segment always sits behind a shown first segment.
	a_pend_behind: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> result_valid_q)
		else $error("second segment held without a result on the output");

	// Taking a non-final result brings up the final segment at ring offset zero.
	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_stall && !last) |=>
		(result_valid && last && seg_offset == '0))
		else $error("second segment did not follow the first");

	// The reduction pass always ends with both index units together.
	a_pass_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		wr_busy == rd_busy)
		else $error("index reduction units out of step");

endmodule

`default_nettype wire

[rtl/crpt_mod_pipe.sv]
//------------------------------------------------------------------------------
// crpt_mod_pipe: address offset remainder pipeline
// Reduces a 32-bit offset modulo the ring size, four bits per stage, with
// per-stage valid bits so that bubbles close up while the output is held.
//------------------------------------------------------------------------------
`default_nettype none

module crpt_mod_pipe import crpt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [ADDR_W-1:0] in_diff,
	input  wire item_tag_t         in_tag,
	input  wire logic [SIZE_W-1:0] s,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [IDX_W-1:0]       out_rem,
	output item_tag_t              out_tag
);

	logic                v_s   [0:DIV_STAGES];
	logic [ADDR_W-1:0]   div_s [0:DIV_STAGES];
	logic [IDX_W-1:0]    rem_s [0:DIV_STAGES];
	item_tag_t           tag_s [0:DIV_STAGES];

	logic [DIV_STAGES:0] load;
	logic [IDX_W-1:0]    nxt_rem [0:DIV_STAGES-1];
	logic [ADDR_W-1:0]   nxt_div [0:DIV_STAGES-1];

	// A stage takes new contents when it is empty or its contents move on.
	always_comb begin
		load[DIV_STAGES] = !v_s[DIV_STAGES] || out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			load[k] = !v_s[k] || load[k+1];
		end
	end

	always_comb begin
		logic [IDX_W-1:0]  r;
		logic [ADDR_W-1:0] d;
		for (int k = 0; k < DIV_STAGES; k++) begin
			r = rem_s[k];
			d = div_s[k];
			for (int j = 0; j < STEP_BITS; j++) begin
				r = mod_step(r, d[ADDR_W-1], s);
				d = {d[ADDR_W-2:0], 1'b0};
			end
			nxt_rem[k] = r;
			nxt_div[k] = d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) begin
				v_s[k] <= 1'b0;
			end
		end else begin
			if (load[0]) begin
				v_s[0] <= in_valid;
			end
			for (int k = 1; k <= DIV_STAGES; k++) begin
				if (load[k]) begin
					v_s[k] <= v_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load[0] && in_valid) begin
			div_s[0] <= in_diff;
			rem_s[0] <= '0;
			tag_s[0] <= in_tag;
		end
		for (int k = 1; k <= DIV_STAGES; k++) begin
			if (load[k] && v_s[k-1]) begin
				div_s[k] <= nxt_div[k-1];
				rem_s[k] <= nxt_rem[k-1];
				tag_s[k] <= tag_s[k-1];
			end
		end
	end

	assign in_ready  = load[0];
	assign out_valid = v_s[DIV_STAGES];
	assign out_rem   = rem_s[DIV_STAGES];
	assign out_tag   = tag_s[DIV_STAGES];

	// A held output keeps its remainder and its tag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_rem) && $stable(out_tag)))
		else $error("offset pipeline dropped or changed a held item");

endmodule

`default_nettype wire

[rtl/crpt_idx_reduce.sv]
//------------------------------------------------------------------------------
// crpt_idx_reduce: iterative index reduction
// Reduces a stored ring index modulo a new ring size, one bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none

module crpt_idx_reduce import crpt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [IDX_W-1:0]  raw,
	input  wire logic [SIZE_W-1:0] s,
	output logic                   busy,
	output logic                   done,
	output logic [IDX_W-1:0]       rem
);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IDX_W-1:0] shf_q;
	logic [IDX_W-1:0] rem_q;
	logic [IDX_W-1:0] rem_nxt;

	assign rem_nxt = mod_step(rem_q, shf_q[IDX_W-1], s);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(IDX_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= raw;
			rem_q <= '0;
		end else if (busy_q) begin
			shf_q <= {shf_q[IDX_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (cnt_q == CNT_W'(1)) && !start;
	assign rem  = rem_nxt;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != '0 && cnt_q <= CNT_W'(IDX_W)))
		else $error("index reduction counter out of range while busy");

endmodule

`default_nettype wire

[rtl/crpt_step_logic.sv]
//------------------------------------------------------------------------------
// crpt_step_logic: pointer update for one item
// Given the reduced offset, the ring size and the current pointers, works out
// the next pointers and the one or two result items.
//------------------------------------------------------------------------------
`default_nettype none

module crpt_step_logic import crpt_pkg::*; (
	input  wire item_tag_t         tag,
	input  wire logic [IDX_W-1:0]  offs,
	input  wire logic [SIZE_W-1:0] s,
	input  wire ring_state_t       cur,
	output ring_state_t            nxt,
	output logic                   upd,
	output logic                   two,
	output result_t                res0,
	output result_t                res1
);

	logic [SIZE_W-1:0] offs_w;
	logic [SIZE_W-1:0] wr_w;
	logic [SIZE_W-1:0] nb;
	logic [SIZE_W:0]   bw_sum;
	logic              trim;
	logic [SIZE_W-1:0] half;
	logic [SIZE_W-1:0] rd_trim;

	logic [SIZE_W-1:0] want;
	logic              excess;
	logic [SIZE_W-1:0] bw_eff;
	logic [IDX_W-1:0]  r;
	logic [SIZE_W-1:0] size;
	logic [SIZE_W:0]   seg_end;
	logic              wrap;
	logic [SIZE_W-1:0] first;
	logic [SIZE_W-1:0] second;
	logic              s_zero;

	always_comb begin
		s_zero = (s == '0);

		// Progress report: bytes filled since the last report, modulo the size.
		offs_w = {1'b0, offs};
		wr_w   = {1'b0, cur.wr};
		if (offs_w >= wr_w) begin
			nb = offs_w - wr_w;
		end else begin
			nb = (s - wr_w) + offs_w;
		end
		bw_sum  = {1'b0, cur.bw} + {1'b0, nb};
		trim    = bw_sum > {1'b0, s};
		half    = s >> 1;
		rd_trim = offs_w + (s - half);
		if (rd_trim >= s) begin
			rd_trim = rd_trim - s;
		end

		// Read request.
		want   = {tag.frames, 2'b00};
		excess = cur.bw > s;
		bw_eff = excess ? '0 : cur.bw;
		r      = excess ? cur.wr : cur.rd;
		size   = (want > bw_eff) ? bw_eff : want;
		seg_end = {2'b00, r} + {1'b0, size};
		wrap   = seg_end >= {1'b0, s};
		first  = s - {1'b0, r};
		second = size - first;

		nxt       = cur;
		upd       = 1'b0;
		two       = 1'b0;
		res0      = '0;
		res0.kind = KIND_IGNORED;
		res0.last = 1'b1;
		res1      = '0;
		res1.kind = KIND_SEGMENT;
		res1.last = 1'b1;

		unique case (tag.mode)
			MODE_STOP: begin
				nxt       = '0;
				upd       = 1'b1;
				res0.kind = KIND_CLEARED;
			end
			MODE_PROGRESS: begin
				if (!tag.addr_zero && !s_zero) begin
					upd       = 1'b1;
					nxt.wr    = offs;
					res0.kind = KIND_PROGRESS;
					res0.new_bytes = nb[IDX_W-1:0];
					if (trim) begin
						nxt.bw        = half;
						nxt.rd        = rd_trim[IDX_W-1:0];
						res0.overflow = 1'b1;
					end else begin
						nxt.bw = bw_sum[SIZE_W-1:0];
					end
				end
			end
			MODE_READ: begin
				if (!s_zero) begin
					upd               = 1'b1;
					nxt.bw            = bw_eff - size;
					res0.kind         = KIND_SEGMENT;
					res0.seg_offset   = r;
					res0.total_frames = size[SIZE_W-1:2];
					if (!wrap) begin
						nxt.rd         = seg_end[IDX_W-1:0];
						res0.seg_bytes = size;
					end else begin
						// The read reaches the end of the ring: a second segment
						// restarts at offset zero.
						two               = 1'b1;
						nxt.rd            = second[IDX_W-1:0];
						res0.seg_bytes    = first;
						res0.last         = 1'b0;
						res1.seg_bytes    = second;
						res1.total_frames = size[SIZE_W-1:2];
					end
				end
			end
			MODE_UNUSED: begin
			end
		endcase
	end

endmodule

`default_nettype wire
